### hw/rtl/clex_pkg.sv
`default_nettype none
package clex_pkg;

   localparam int VALUE_BITS_DEF = 64;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [2:0] K_END   = 3'd0;
   localparam logic [2:0] K_CHAR  = 3'd1;
   localparam logic [2:0] K_INT   = 3'd2;
   localparam logic [2:0] K_FLOAT = 3'd3;
   localparam logic [2:0] K_ERROR = 3'd4;

   localparam logic [2:0] E_NONE      = 3'd0;
   localparam logic [2:0] E_INT_SUFX  = 3'd1;
   localparam logic [2:0] E_OPEN_CMT  = 3'd2;
   localparam logic [2:0] E_BAD_NUM   = 3'd3;
   localparam logic [2:0] E_HEX_NOEXP = 3'd4;
   localparam logic [2:0] E_FLT_SUFX  = 3'd5;

   localparam logic [1:0] W_16 = 2'd0;
   localparam logic [1:0] W_32 = 2'd1;
   localparam logic [1:0] W_64 = 2'd2;

   localparam logic [3:0] M_IDLE       = 4'd0;
   localparam logic [3:0] M_SLASH      = 4'd1;
   localparam logic [3:0] M_LINE       = 4'd2;
   localparam logic [3:0] M_BLOCK      = 4'd3;
   localparam logic [3:0] M_BSTAR      = 4'd4;
   localparam logic [3:0] M_ZERO       = 4'd5;
   localparam logic [3:0] M_DIGITS     = 4'd6;
   localparam logic [3:0] M_FRAC       = 4'd7;
   localparam logic [3:0] M_EXP_START  = 4'd8;
   localparam logic [3:0] M_EXP_DIGITS = 4'd9;
   localparam logic [3:0] M_FLT_SUFFIX = 4'd10;
   localparam logic [3:0] M_INT_SUFFIX = 4'd11;
   localparam logic [3:0] M_AFTER_L    = 4'd12;

   localparam logic [1:0] R_DEC = 2'd0;
   localparam logic [1:0] R_OCT = 2'd1;
   localparam logic [1:0] R_HEX = 2'd2;

   // suffix flag bits
   localparam int F_U  = 0;
   localparam int F_L  = 1;
   localparam int F_LL = 2;
   localparam int F_F  = 3;

   // limits below which an integer without an L suffix gets the 16-bit width
   localparam int INT16_MAX_U = 32767;
   localparam int INT16_MAX_S = 32767 / 2;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] chr;
      logic       uns;
      logic [1:0] wid;
      logic [2:0] err;
      logic       last;
   } meta_type;

   typedef struct packed {
      logic [3:0] mode;
      logic [1:0] radix;
      logic [3:0] flags;
      logic [7:0] lch;
      logic       bad;
   } scan_type;

endpackage
`default_nettype wire

### hw/rtl/clex_front.sv
`default_nettype none
module clex_front #(
   parameter int VALUE_BITS = clex_pkg::VALUE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            ch,
   input  wire logic                  eof,
   output clex_pkg::meta_type         meta0,
   output logic [VALUE_BITS-1:0]      val0,
   output logic                       push0,
   output clex_pkg::meta_type         meta1,
   output logic [VALUE_BITS-1:0]      val1,
   output logic                       push1
);
   import clex_pkg::*;

   typedef struct packed {
      scan_type              s;
      logic [VALUE_BITS-1:0] acc;
      logic                  emit;
      meta_type              m;
      logic [VALUE_BITS-1:0] val;
      logic                  again;
   } step_type;

   scan_type              scan_ff, scan_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   step_type              st1, st2;

   function automatic step_type feed(scan_type s_in, logic [VALUE_BITS-1:0] a_in,
                                     logic e, logic [7:0] c);
      step_type r;
      logic done, dig, letter, hok, blank;
      logic [3:0] hv;
      r = '0;
      r.s = s_in;
      r.acc = a_in;
      done = 1'b0;
      dig = !e && (c inside {[8'h30:8'h39]});
      letter = !e && ((c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]}));
      blank = !e && (c inside {8'h20, 8'h09, 8'h0d, 8'h0a});
      hok = 1'b1;
      hv = c[3:0];
      if (dig) hv = c[3:0];
      else if (!e && ((c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]})))
         hv = c[3:0] + 4'd9;
      else hok = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!done) begin
            done = 1'b1;
            case (r.s.mode)
               M_IDLE: begin
                  if (e) begin
                     r.emit = 1'b1; r.m.kind = K_END;
                  end else if (blank) begin
                  end else if (c == "/") begin
                     r.s.mode = M_SLASH;
                  end else if (dig) begin
                     r.acc = '0; r.s.flags = '0; r.s.lch = '0; r.s.bad = 1'b0;
                     r.s.radix = R_DEC;
                     if (c == "0") r.s.mode = M_ZERO;
                     else begin
                        r.acc = VALUE_BITS'(c[3:0]);
                        r.s.mode = M_DIGITS;
                     end
                  end else begin
                     r.emit = 1'b1; r.m.kind = K_CHAR; r.m.chr = c;
                  end
               end
               M_SLASH: begin
                  if (!e && c == "/") r.s.mode = M_LINE;
                  else if (!e && c == "*") r.s.mode = M_BLOCK;
                  else begin
                     r.emit = 1'b1; r.m.kind = K_CHAR; r.m.chr = "/";
                     r.s.mode = M_IDLE; r.again = 1'b1;
                  end
               end
               M_LINE: begin
                  if (e) begin
                     r.s.mode = M_IDLE; r.again = 1'b1;
                  end else if (c == 8'h0a) r.s.mode = M_IDLE;
               end
               M_BLOCK, M_BSTAR: begin
                  if (e) begin
                     r.emit = 1'b1; r.m.kind = K_ERROR; r.m.err = E_OPEN_CMT;
                     r.s.mode = M_IDLE; r.again = 1'b1;
                  end else if (r.s.mode == M_BSTAR && c == "/") r.s.mode = M_IDLE;
                  else r.s.mode = (c == "*") ? M_BSTAR : M_BLOCK;
               end
               M_ZERO: begin
                  r.s.mode = M_DIGITS;
                  if (!e && (c == "x" || c == "X")) r.s.radix = R_HEX;
                  else begin
                     r.s.radix = R_OCT; done = 1'b0;
                  end
               end
               M_DIGITS: begin
                  if (r.s.radix == R_HEX) begin
                     if (hok) r.acc = (r.acc << 4) + VALUE_BITS'(hv);
                     else if (!e && c == ".") r.s.mode = M_FRAC;
                     else begin
                        r.s.mode = M_INT_SUFFIX; done = 1'b0;
                     end
                  end else if (dig) begin
                     if (r.s.radix == R_DEC)
                        r.acc = (r.acc << 3) + (r.acc << 1) + VALUE_BITS'(c[3:0]);
                     else r.acc = (r.acc << 3) + VALUE_BITS'(c[3:0]);
                  end else if (!e && c == ".") begin
                     if (r.s.radix == R_OCT && r.acc != '0) begin
                        r.emit = 1'b1; r.m.kind = K_ERROR; r.m.err = E_BAD_NUM;
                        r.s.mode = M_IDLE;
                     end else begin
                        r.s.radix = R_DEC; r.s.mode = M_FRAC;
                     end
                  end else if (!e && (c == "e" || c == "E")) r.s.mode = M_EXP_START;
                  else begin
                     r.s.mode = M_INT_SUFFIX; done = 1'b0;
                  end
               end
               M_FRAC: begin
                  if (r.s.radix == R_HEX) begin
                     if (hok) begin
                     end else if (!e && (c == "p" || c == "P")) r.s.mode = M_EXP_START;
                     else begin
                        r.emit = 1'b1; r.m.kind = K_ERROR; r.m.err = E_HEX_NOEXP;
                        r.s.mode = M_IDLE; r.again = 1'b1;
                     end
                  end else if (dig) begin
                  end else if (!e && (c == "e" || c == "E")) r.s.mode = M_EXP_START;
                  else begin
                     r.s.mode = M_FLT_SUFFIX; done = 1'b0;
                  end
               end
               M_EXP_START: begin
                  r.s.mode = M_EXP_DIGITS;
                  if (!(!e && (c == "+" || c == "-"))) done = 1'b0;
               end
               M_EXP_DIGITS: begin
                  if (!dig) begin
                     r.s.mode = M_FLT_SUFFIX; done = 1'b0;
                  end
               end
               M_FLT_SUFFIX: begin
                  if (letter) begin
                     if (r.s.bad) begin
                     end else if ((c == "f" || c == "F") && !r.s.flags[F_F])
                        r.s.flags[F_F] = 1'b1;
                     else if ((c == "l" || c == "L") && !r.s.flags[F_L])
                        r.s.flags[F_L] = 1'b1;
                     else r.s.bad = 1'b1;
                  end else begin
                     r.emit = 1'b1;
                     if (r.s.bad) begin
                        r.m.kind = K_ERROR; r.m.err = E_FLT_SUFX;
                     end else begin
                        r.m.kind = K_FLOAT;
                        r.m.wid = r.s.flags[F_F] ? W_32 : W_64;
                     end
                     r.s.mode = M_IDLE; r.again = 1'b1;
                  end
               end
               M_INT_SUFFIX: begin
                  if (letter) begin
                     if (r.s.bad) begin
                     end else if ((c == "u" || c == "U") && !r.s.flags[F_U])
                        r.s.flags[F_U] = 1'b1;
                     else if ((c == "l" || c == "L") && !r.s.flags[F_L] && !r.s.flags[F_LL])
                     begin
                        r.s.lch = c; r.s.mode = M_AFTER_L;
                     end else r.s.bad = 1'b1;
                  end else begin
                     r.emit = 1'b1;
                     if (r.s.bad) begin
                        r.m.kind = K_ERROR; r.m.err = E_INT_SUFX;
                     end else begin
                        r.m.kind = K_INT;
                        r.m.uns = r.s.flags[F_U];
                        r.val = r.acc;
                        if (r.s.flags[F_LL]) r.m.wid = W_64;
                        else if (r.s.flags[F_L]) r.m.wid = W_32;
                        else if ((r.s.flags[F_U] && r.acc < VALUE_BITS'(INT16_MAX_U)) ||
                                 (!r.s.flags[F_U] && r.acc < VALUE_BITS'(INT16_MAX_S)))
                           r.m.wid = W_16;
                        else r.m.wid = W_32;
                     end
                     r.s.mode = M_IDLE; r.again = 1'b1;
                  end
               end
               M_AFTER_L: begin
                  r.s.mode = M_INT_SUFFIX;
                  if (!e && c == r.s.lch) r.s.flags[F_LL] = 1'b1;
                  else begin
                     r.s.flags[F_L] = 1'b1; done = 1'b0;
                  end
               end
               default: begin
                  r.s.mode = M_IDLE; done = 1'b0;
               end
            endcase
         end
      end
      return r;
   endfunction

   always_comb begin
      st1 = feed(scan_ff, acc_ff, eof, ch);
      st2 = '0;
      st2.s = st1.s;
      st2.acc = st1.acc;
      if (st1.again) st2 = feed(st1.s, st1.acc, eof, ch);
      scan_in = st2.s;
      acc_in = st2.acc;
   end

   // the two results are packed so the first written slot is always used
   always_comb begin
      meta0 = st1.emit ? st1.m : st2.m;
      val0 = st1.emit ? st1.val : st2.val;
      meta0.last = !(st1.emit && st2.emit);
      push0 = accept && (st1.emit || st2.emit);
      meta1 = st2.m;
      meta1.last = 1'b1;
      val1 = st2.val;
      push1 = accept && st1.emit && st2.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         acc_ff <= '0;
      end else if (accept) begin
         scan_ff <= scan_in;
         acc_ff <= acc_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/clex_queue.sv
`default_nettype none
module clex_queue #(
   parameter int VALUE_BITS = clex_pkg::VALUE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire clex_pkg::meta_type    meta0,
   input  wire logic [VALUE_BITS-1:0] val0,
   input  wire logic                  push0,
   input  wire clex_pkg::meta_type    meta1,
   input  wire logic [VALUE_BITS-1:0] val1,
   input  wire logic                  push1,
   input  wire logic                  pop,
   output logic                       not_empty,
   output logic                       full2,
   output clex_pkg::meta_type         head_meta,
   output logic [VALUE_BITS-1:0]      head_val
);
   import clex_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   meta_type              meta_ff [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0] val_ff [QUEUE_DEPTH];
   logic [PW-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]           cnt_ff, cnt_in;
   logic [PW-1:0]         wr_next;

   assign wr_next = wr_ff + PW'(1);
   assign not_empty = cnt_ff != '0;
   // room for two results is needed before an item may enter
   assign full2 = cnt_ff > (PW+1)'(QUEUE_DEPTH - 2);
   assign head_meta = meta_ff[rd_ff];
   assign head_val = val_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff + PW'(push0) + PW'(push1);
      rd_in = rd_ff + PW'(pop);
      cnt_in = cnt_ff + (PW+1)'(push0) + (PW+1)'(push1) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         meta_ff[wr_ff] <= meta0;
         val_ff[wr_ff] <= val0;
      end
      if (push1) begin
         meta_ff[wr_next] <= meta1;
         val_ff[wr_next] <= val1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0) else $error("second result without first");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      push0 && !push1 && !pop |=> cnt_ff == $past(cnt_ff) + (PW+1)'(1))
      else $error("queue count step");

endmodule
`default_nettype wire

### hw/rtl/clex_back.sv
`default_nettype none
module clex_back #(
   parameter int VALUE_BITS = clex_pkg::VALUE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  not_empty,
   input  wire clex_pkg::meta_type    head_meta,
   input  wire logic [VALUE_BITS-1:0] head_val,
   output logic                       pop,
   input  wire logic                  out_stall,
   output logic                       out_valid,
   output clex_pkg::meta_type         out_meta,
   output logic [VALUE_BITS-1:0]      out_val
);
   import clex_pkg::*;

   logic                  valid_ff;
   meta_type              meta_ff;
   logic [VALUE_BITS-1:0] val_ff;

   assign pop = not_empty && (!valid_ff || !out_stall);
   assign out_valid = valid_ff;
   assign out_meta = meta_ff;
   assign out_val = val_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (!valid_ff || !out_stall) valid_ff <= not_empty;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         meta_ff <= head_meta;
         val_ff <= head_val;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && out_stall |=> valid_ff && $stable(val_ff))
      else $error("stalled result changed");
   a_kind_ok: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> meta_ff.kind == K_INT || val_ff == '0)
      else $error("value on non-integer");
   a_char_ok: assert property (@(posedge clock) disable iff (reset)
      valid_ff && meta_ff.kind != K_CHAR |-> meta_ff.chr == 8'h00)
      else $error("char on non-char result");

endmodule
`default_nettype wire

### hw/rtl/c_number_and_comment_lexer.sv
`default_nettype none
// channel | ports                                     | direction
// req     | req_valid req_stall req_ch req_end_of_file | in
// rsp     | rsp_valid rsp_stall rsp_kind .. rsp_last    | out
//
// One byte is taken per cycle while req_stall is low; each item gives zero, one or two results.
// Results leave one per cycle while rsp_stall is low, so a stream of two-result items runs at half rate.
// A result is written into the queue at the accepting edge, then into the output register that drives rsp_valid.
// req_stall rises when the 4-entry result queue has room for fewer than two results.
// Reset is synchronous and returns the scanner to idle between tokens.
module c_number_and_comment_lexer #(
   parameter int VALUE_BITS = clex_pkg::VALUE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_ch,
   input  wire logic                  req_end_of_file,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [2:0]                 rsp_kind,
   output logic [7:0]                 rsp_char_code,
   output logic [VALUE_BITS-1:0]      rsp_int_value,
   output logic                       rsp_is_unsigned,
   output logic [1:0]                 rsp_width_code,
   output logic [2:0]                 rsp_error_code,
   output logic                       rsp_last
);
   import clex_pkg::*;

   meta_type              meta0, meta1, head_meta, out_meta;
   logic [VALUE_BITS-1:0] val0, val1, head_val;
   logic                  push0, push1, pop, not_empty, full2, accept;

   assign req_stall = full2;
   assign accept = req_valid && !full2;

   clex_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .ch(req_ch), .eof(req_end_of_file),
      .meta0(meta0), .val0(val0), .push0(push0),
      .meta1(meta1), .val1(val1), .push1(push1)
   );

   clex_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
      .clock(clock), .reset(reset),
      .meta0(meta0), .val0(val0), .push0(push0),
      .meta1(meta1), .val1(val1), .push1(push1),
      .pop(pop), .not_empty(not_empty), .full2(full2),
      .head_meta(head_meta), .head_val(head_val)
   );

   clex_back #(.VALUE_BITS(VALUE_BITS)) u_back (
      .clock(clock), .reset(reset),
      .not_empty(not_empty), .head_meta(head_meta), .head_val(head_val),
      .pop(pop), .out_stall(rsp_stall), .out_valid(rsp_valid),
      .out_meta(out_meta), .out_val(rsp_int_value)
   );

   assign rsp_kind = out_meta.kind;
   assign rsp_char_code = out_meta.chr;
   assign rsp_is_unsigned = out_meta.uns;
   assign rsp_width_code = out_meta.wid;
   assign rsp_error_code = out_meta.err;
   assign rsp_last = out_meta.last;

endmodule
`default_nettype wire
